/* hdl/signed_decimal_to_ascii_defines.svh */
// Assertion helpers for the RTL; only sda_back.sv includes them.
`ifndef SIGNED_DECIMAL_TO_ASCII_DEFINES_SVH
`define SIGNED_DECIMAL_TO_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sda assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sda assertion failed");

`endif

/* hdl/sda_pkg.sv */
package sda_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } t_back_state;

endpackage

/* hdl/sda_in_if.sv */
interface sda_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sda_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* hdl/sda_out_if.sv */
interface sda_out_if;
    logic                        valid;
    logic                        ready;
    logic [sda_pkg::CHAR_W-1:0]  char_code;
    logic                        last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hdl/signed_decimal_to_ascii.sv */
// Signed 32-bit integer to decimal ASCII text.
// i_in carries one transaction per number (value, two's complement).
// o_out carries one transaction per character: char_code is '-' or a digit,
// most significant first, with last set on the final character of a number.
// Zero prints as a single '0'; there are no leading zeros.
// A front stage negates and classifies each number into a two-entry queue;
// the back end runs a serial shift-and-add-3 conversion, then walks the
// MAX_DIGITS BCD digits one per cycle from the top unless the output register
// is held by a stall, presenting the '-' before the digits for a negative number.
// If the receiver stalls, the output register holds its character, the back
// end waits, and the queue absorbs up to two more numbers before i_in.ready drops.
// Reset (synchronous, active low) empties the queue and the output register.
module signed_decimal_to_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sda_in_if.sink    i_in,
    sda_out_if.source o_out
);
    import sda_pkg::*;

    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;

    sda_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    sda_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_pop_item  (w_pop_item)
    );

    sda_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

/* hdl/sda_queue.sv */
module sda_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sda_pkg::t_item i_push_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sda_pkg::t_item o_pop_item
);
    import sda_pkg::*;

    localparam int DEPTH = 2;

    t_item      r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full     = (r_count == 2'(DEPTH));
    assign o_empty    = (r_count == 2'd0);
    assign o_pop_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/sda_front.sv */
module sda_front (
    sda_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output sda_pkg::t_item o_item
);
    import sda_pkg::*;

    logic [VALUE_W-1:0] w_raw;

    assign w_raw      = $unsigned(i_in.value);
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // take the magnitude as unsigned so the most negative value survives
    assign o_item.neg = w_raw[VALUE_W-1];
    assign o_item.mag = w_raw[VALUE_W-1] ? (~w_raw + VALUE_W'(1)) : w_raw;

endmodule

/* hdl/sda_back.sv */
`include "signed_decimal_to_ascii_defines.svh"

module sda_back #(
    parameter int MAX_DIGITS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sda_pkg::t_item i_item,
    output logic           o_pop,
    sda_out_if.source      o_out
);
    import sda_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2((MAX_DIGITS > VALUE_W) ? MAX_DIGITS : VALUE_W);

    t_back_state        r_state, n_state;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic               r_ovf, n_ovf;
    logic               r_neg, n_neg;
    logic               r_started, n_started;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;

    logic [BCD_W-1:0]   w_adj;
    logic [DIGIT_W-1:0] w_top;
    logic               w_load_ok;
    logic               w_emit;

    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            w_adj[d*DIGIT_W +: DIGIT_W] = (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) ?
                r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3 : r_bcd[d*DIGIT_W +: DIGIT_W];
        end
    end

    assign w_top     = r_bcd[BCD_W-1 -: DIGIT_W];
    assign w_load_ok = !r_out_valid || o_out.ready;
    assign w_emit    = r_started || (w_top != '0) || (r_cnt == '0);

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_ovf       = r_ovf;
        n_neg       = r_neg;
        n_started   = r_started;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_mag   = i_item.mag;
                    n_neg   = i_item.neg;
                    n_bcd   = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = CNT_W'(VALUE_W - 1);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // shift-and-add-3; a bit leaving the top digit means truncation
                n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_W-1]};
                n_ovf = r_ovf | w_adj[BCD_W-1];
                n_mag = r_mag << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_cnt     = CNT_W'(MAX_DIGITS - 1);
                    n_started = n_ovf;
                    n_state   = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (w_load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (!w_emit) begin
                    // drop a leading zero
                    n_bcd = r_bcd << DIGIT_W;
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (w_load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_ZERO + CHAR_W'(w_top);
                    n_out_last  = (r_cnt == '0);
                    n_started   = 1'b1;
                    n_bcd       = r_bcd << DIGIT_W;
                    n_cnt       = r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_ovf       <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last      = r_out_last;

    `SDA_ASSERT_NXT(a_conv_end, i_clk, i_rst_n, (r_state == ST_CONV && r_cnt == '0), (r_state != ST_CONV))
    `SDA_ASSERT_IMP(a_sign_neg, i_clk, i_rst_n, (r_state == ST_SIGN), r_neg)
    `SDA_ASSERT_IMP(a_ovf_started, i_clk, i_rst_n, (r_state == ST_DIGIT && r_ovf), r_started)

endmodule

/* dv/signed_decimal_to_ascii_test.sv */
`timescale 1ns / 1ps

module signed_decimal_to_ascii_test;
    import sda_pkg::*;

    localparam int DIGITS        = 10;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int DIRECTED_N    = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_char;

    logic clk;
    logic rst_n;

    sda_in_if  in_if ();
    sda_out_if out_if ();

    signed_decimal_to_ascii #(
        .MAX_DIGITS(DIGITS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_char       expected_chars[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned chars_checked;
    int unsigned numbers_printed;
    int unsigned numbers_sent;
    int unsigned negatives_sent;
    int unsigned zeros_sent;
    int unsigned random_sent;
    int unsigned input_stalls;
    int unsigned holds_done;
    int unsigned burst_left;

    logic [VALUE_W-1:0] directed_value [DIRECTED_N] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10,
        32'hFFFF_FFF6, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, 32'hC465_3601, 32'd100, 32'hFFFF_FFFB, 32'd12345,
        32'hB669_FD2E, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, 32'd1000000001
    };
    string directed_text [DIRECTED_N] = '{
        "0", "1", "-1", "9", "10",
        "", "2147483647", "-2147483648", "-2147483647", "1000000000",
        "", "", "", "-5", "",
        "", "", "", "", ""
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digit [DIGITS];
        t_char              c;
        int                 nd;
        mag = raw[VALUE_W-1] ? 32'd0 - raw : raw;
        if (raw[VALUE_W-1]) begin
            c.char_code = CH_MINUS;
            c.last      = 1'b0;
            expected_chars.push_back(c);
        end
        if (mag == 0) begin
            c.char_code = CH_ZERO;
            c.last      = 1'b1;
            expected_chars.push_back(c);
            return;
        end
        nd = 0;
        while (mag != 0 && nd < DIGITS) begin
            digit[nd] = DIGIT_W'(mag % 10);
            mag       = mag / 10;
            nd++;
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.char_code = CH_ZERO + CHAR_W'(digit[i]);
            c.last      = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic void expect_text(input string text);
        t_char c;
        for (int i = 0; i < text.len(); i++) begin
            c.char_code = text[i];
            c.last      = (i == text.len() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic int unsigned pow10(input int unsigned n);
        int unsigned p;
        p = 1;
        repeat (n) p *= 10;
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned        kind;
        int unsigned        d;
        logic [VALUE_W-1:0] mag;
        logic               neg;
        kind = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        case (kind)
            0, 1: begin
                return $urandom;
            end
            2, 3: begin
                mag = $urandom_range(0, 120);
            end
            4, 5: begin
                mag = pow10($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
            end
            8: begin
                d   = $urandom_range(0, 2);
                mag = (d == 0) ? 32'd0 : (d == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default: begin
                d   = $urandom_range(1, 10);
                mag = $urandom_range((d == 1) ? 0 : pow10(d - 1),
                                     (d == 10) ? 32'h7FFF_FFFF : pow10(d) - 1);
            end
        endcase
        return neg ? 32'd0 - mag : mag;
    endfunction

    // hold valid across back-to-back transactions; drop it only for a gap
    task automatic offer_number(input logic [VALUE_W-1:0] v, input string text);
        int unsigned gap;
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge clk); while (!in_if.ready);
        if (text.len() != 0) expect_text(text);
        else predict_text(v);
        numbers_sent++;
        if (v[VALUE_W-1]) negatives_sent++;
        if (v == 0) zeros_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 10);
        end
    endtask

    initial begin : stimulus
        rst_n       <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        burst_left   = 3;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_N; i++) begin
            offer_number(directed_value[i], directed_text[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            offer_number(pick_value(), "");
            random_sent++;
        end
        in_if.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d numbers (%0d negative, %0d zero), %0d characters checked",
                 numbers_sent, negatives_sent, zeros_sent, chars_checked);
        $display("input held off for %0d cycles, %0d long receiver hold-offs, %0d errors",
                 input_stalls, holds_done, errors);
        if (errors == 0) begin
            $display("signed_decimal_to_ascii_test: done, clean");
        end else begin
            $display("signed_decimal_to_ascii_test: done, errors");
        end
        $finish;
    end

    initial begin : receiver
        logic [7:0]  pattern;
        int unsigned rx_cycle;
        pattern       = 8'hFF;
        rx_cycle      = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle % 64 == 0) begin
                pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom) | 8'h01;
            end
            if (holds_done < 2 && random_sent >= (holds_done + 1) * 150) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end else begin
                out_if.ready <= pattern[rx_cycle % 8];
            end
        end
    end

    always @(posedge clk) begin : check_chars
        t_char want;
        if (rst_n && in_if.valid && !in_if.ready) input_stalls++;
        if (rst_n && out_if.valid && out_if.ready) begin
            chars_checked++;
            if (out_if.last === 1'b1) numbers_printed++;
            if (expected_chars.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected char %h last %b", out_if.char_code, out_if.last);
                end
            end else begin
                want = expected_chars.pop_front();
                if (want.char_code !== out_if.char_code || want.last !== out_if.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("char %0d: expected %h last %b, got %h last %b",
                                 chars_checked, want.char_code, want.last,
                                 out_if.char_code, out_if.last);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("signed_decimal_to_ascii_test: done, errors");
            $finish;
        end
    end

endmodule
